@@ sv/timestamp_ordered_event_queue_assert.svh @@
// Assertion macros used by the event queue back end
`ifndef TIMESTAMP_ORDERED_EVENT_QUEUE_ASSERT_SVH
`define TIMESTAMP_ORDERED_EVENT_QUEUE_ASSERT_SVH

// condition must hold at every edge out of reset
`define TSQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define TSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define TSQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/tsq_pkg.sv @@
// Types and constants of the timestamp ordered event queue
`default_nettype none
package tsq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DISCARD = 2'd1,
    OP_RESCHED = 2'd2,
    OP_POP     = 2'd3
  } op_t;

  localparam logic [1:0] CLS_STATE  = 2'd1;
  localparam logic [1:0] CLS_GSTART = 2'd2;

  typedef enum logic [2:0] {
    RK_DONE    = 3'd0,
    RK_RELEASE = 3'd1,
    RK_POPPED  = 3'd2,
    RK_EMPTY   = 3'd3,
    RK_FULL    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [31:0] tstamp;
    logic [7:0]  code;
    logic [1:0]  cls;
    logic [7:0]  pin;
    logic [31:0] pay;
  } entry_t;

  typedef struct packed {
    op_t    op;
    entry_t ent;
    logic   blob;
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_IW_WAIT, ST_IW_EVAL,
    ST_IS_WAIT, ST_IS_EVAL,
    ST_IN_PUT,
    ST_DK_WAIT, ST_DK_EVAL,
    ST_DR_WAIT, ST_DR_EVAL,
    ST_DC_WAIT, ST_DC_EVAL,
    ST_RS_WAIT, ST_RS_EVAL,
    ST_PP_WAIT, ST_PP_EVAL,
    ST_PS_WAIT, ST_PS_EVAL,
    ST_DONE
  } bk_state_t;

endpackage
`default_nettype wire

@@ sv/tsq_front.sv @@
// Front end: takes input requests and packs them into commands
`default_nettype none
module tsq_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_opcode,
  input  wire logic [31:0]   in_time_stamp,
  input  wire logic [7:0]    in_event_code,
  input  wire logic [1:0]    in_event_class,
  input  wire logic [7:0]    in_pin_index,
  input  wire logic [31:0]   in_payload,
  input  wire logic          in_payload_is_blob,
  output logic               push_valid,
  input  wire logic          push_ready,
  output tsq_pkg::cmd_t      push_cmd
);

  logic          valid_r, valid_nxt;
  tsq_pkg::cmd_t cmd_r, cmd_nxt;
  logic          take;

  assign in_ready   = !valid_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_cmd   = cmd_r;

  // decode the opcode and pack the entry fields
  always_comb begin
    cmd_nxt = cmd_r;
    if (take) begin
      cmd_nxt.op         = tsq_pkg::op_t'(in_opcode);
      cmd_nxt.ent.tstamp = in_time_stamp;
      cmd_nxt.ent.code   = in_event_code;
      cmd_nxt.ent.cls    = in_event_class;
      cmd_nxt.ent.pin    = in_pin_index;
      cmd_nxt.ent.pay    = in_payload;
      cmd_nxt.blob       = in_payload_is_blob;
    end
    valid_nxt = take || (valid_r && !push_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule
`default_nettype wire

@@ sv/tsq_fifo.sv @@
// Two-entry command queue between front and back end
`default_nettype none
module tsq_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  tsq_pkg::cmd_t      push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output tsq_pkg::cmd_t      pop_cmd
);

  tsq_pkg::cmd_t slot_r [2];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign push_ready = fill_r != 2'd2;
  assign pop_valid  = fill_r != 2'd0;
  assign pop_cmd    = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wp_nxt   = do_push ? !wp_r : wp_r;
    rp_nxt   = do_pop ? !rp_r : rp_r;
    fill_nxt = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ sv/tsq_back.sv @@
// Back end: sequencer over the sorted entry memory and the result register
`default_nettype none
`include "timestamp_ordered_event_queue_assert.svh"
module tsq_back #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  tsq_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         out_result_kind,
  output logic [31:0]        out_time_out,
  output logic [7:0]         out_code_out,
  output logic [1:0]         out_class_out,
  output logic [7:0]         out_pin_out,
  output logic [31:0]        out_payload_out,
  output logic               out_last
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);

  tsq_pkg::bk_state_t state_r, state_nxt;
  tsq_pkg::cmd_t      it_r, it_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt, idx_r, idx_nxt, w_r, w_nxt;
  logic [CW-1:0]      pos_r, pos_nxt, keep_r, keep_nxt;
  logic               repl_r, repl_nxt;
  tsq_pkg::kind_t     fin_r, fin_nxt;

  tsq_pkg::entry_t    mem [QUEUE_DEPTH];
  tsq_pkg::entry_t    rdata_r, wr_data;
  logic [IW-1:0]      rd_addr, wr_addr;
  logic               wr_en;

  logic               ov_r, ov_nxt;
  tsq_pkg::kind_t     ok_r, ok_nxt;
  tsq_pkg::entry_t    oe_r, oe_nxt;
  logic               ol_r, ol_nxt;

  // shared decisions on the entry just read
  logic [CW-1:0]   jdx;
  logic            slot_free, d_gt, d_lt, pin_hit, rel_need, full;
  logic            iw_stop, iw_repl, iw_hold;
  logic [CW-1:0]   iw_pos;
  logic            dc_del;
  tsq_pkg::entry_t d;

  assign d         = rdata_r;
  assign jdx       = idx_r - ONE;
  assign slot_free = !ov_r || out_ready;
  assign d_gt      = d.tstamp > it_r.ent.tstamp;
  assign d_lt      = d.tstamp < it_r.ent.tstamp;
  assign pin_hit   = (d.cls == tsq_pkg::CLS_STATE) && (d.pin == it_r.ent.pin);
  assign rel_need  = it_r.blob && (d.pay != 32'd0);
  assign full      = cnt_r == FULL_CNT;
  assign dc_del    = (idx_r < keep_r) && pin_hit;
  assign cmd_ready = state_r == tsq_pkg::ST_IDLE;

  // insertion walk: stop, replace and position for the entry at idx_r-1
  always_comb begin
    iw_stop = 1'b1;
    iw_repl = 1'b0;
    iw_pos  = idx_r;
    if (d_gt) begin
      iw_stop = 1'b0;
    end else if (it_r.ent.cls != tsq_pkg::CLS_STATE) begin
      iw_pos = idx_r;
    end else if (d_lt || d.cls == tsq_pkg::CLS_GSTART) begin
      iw_pos = idx_r;
    end else if (d.cls == tsq_pkg::CLS_STATE && d.pin <= it_r.ent.pin) begin
      if (d.pin == it_r.ent.pin) begin
        iw_repl = 1'b1;
        iw_pos  = jdx;
      end
    end else begin
      iw_stop = 1'b0;
    end
    // ran off the head: new entry goes first
    if (!iw_stop && jdx == '0) begin
      iw_stop = 1'b1;
      iw_pos  = '0;
    end
    iw_hold = iw_stop && iw_repl && rel_need && !slot_free;
  end

  // read address follows the walk direction of each phase
  always_comb begin
    case (state_r)
      tsq_pkg::ST_IW_WAIT, tsq_pkg::ST_IW_EVAL, tsq_pkg::ST_DK_WAIT,
      tsq_pkg::ST_DK_EVAL, tsq_pkg::ST_DR_WAIT, tsq_pkg::ST_DR_EVAL,
      tsq_pkg::ST_IS_WAIT, tsq_pkg::ST_IS_EVAL: rd_addr = IW'(jdx);
      tsq_pkg::ST_PP_WAIT, tsq_pkg::ST_PP_EVAL: rd_addr = '0;
      default: rd_addr = IW'(idx_r);
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            tsq_pkg::OP_INSERT:
              state_nxt = (cnt_r == '0) ? tsq_pkg::ST_IN_PUT : tsq_pkg::ST_IW_WAIT;
            tsq_pkg::OP_DISCARD:
              state_nxt = (cnt_r == '0) ? tsq_pkg::ST_DONE : tsq_pkg::ST_DK_WAIT;
            tsq_pkg::OP_RESCHED:
              state_nxt = (cnt_r == '0) ? tsq_pkg::ST_DONE : tsq_pkg::ST_RS_WAIT;
            default:
              state_nxt = (cnt_r == '0) ? tsq_pkg::ST_DONE : tsq_pkg::ST_PP_WAIT;
          endcase
        end
      end
      tsq_pkg::ST_IW_WAIT: state_nxt = tsq_pkg::ST_IW_EVAL;
      tsq_pkg::ST_IW_EVAL: begin
        if (!iw_stop) begin
          state_nxt = tsq_pkg::ST_IW_WAIT;
        end else if (iw_hold) begin
          state_nxt = tsq_pkg::ST_IW_EVAL;
        end else if (iw_repl) begin
          state_nxt = tsq_pkg::ST_IN_PUT;
        end else if (full) begin
          state_nxt = tsq_pkg::ST_DONE;
        end else if (iw_pos == cnt_r) begin
          state_nxt = tsq_pkg::ST_IN_PUT;
        end else begin
          state_nxt = tsq_pkg::ST_IS_WAIT;
        end
      end
      tsq_pkg::ST_IS_WAIT: state_nxt = tsq_pkg::ST_IS_EVAL;
      tsq_pkg::ST_IS_EVAL:
        state_nxt = (jdx == pos_r) ? tsq_pkg::ST_IN_PUT : tsq_pkg::ST_IS_WAIT;
      tsq_pkg::ST_IN_PUT: state_nxt = tsq_pkg::ST_DONE;
      tsq_pkg::ST_DK_WAIT: state_nxt = tsq_pkg::ST_DK_EVAL;
      tsq_pkg::ST_DK_EVAL: begin
        if (pin_hit && !d_gt) begin
          state_nxt = (jdx != '0) ? tsq_pkg::ST_DR_WAIT : tsq_pkg::ST_DONE;
        end else begin
          state_nxt = (jdx == '0) ? tsq_pkg::ST_DONE : tsq_pkg::ST_DK_WAIT;
        end
      end
      tsq_pkg::ST_DR_WAIT: state_nxt = tsq_pkg::ST_DR_EVAL;
      tsq_pkg::ST_DR_EVAL: begin
        if (pin_hit && rel_need && !slot_free) begin
          state_nxt = tsq_pkg::ST_DR_EVAL;
        end else begin
          state_nxt = (jdx == '0) ? tsq_pkg::ST_DC_WAIT : tsq_pkg::ST_DR_WAIT;
        end
      end
      tsq_pkg::ST_DC_WAIT: state_nxt = tsq_pkg::ST_DC_EVAL;
      tsq_pkg::ST_DC_EVAL:
        state_nxt = (idx_r + ONE == cnt_r) ? tsq_pkg::ST_DONE : tsq_pkg::ST_DC_WAIT;
      tsq_pkg::ST_RS_WAIT: state_nxt = tsq_pkg::ST_RS_EVAL;
      tsq_pkg::ST_RS_EVAL: begin
        if (d_lt && idx_r + ONE != cnt_r) begin
          state_nxt = tsq_pkg::ST_RS_WAIT;
        end else begin
          state_nxt = tsq_pkg::ST_DONE;
        end
      end
      tsq_pkg::ST_PP_WAIT: state_nxt = tsq_pkg::ST_PP_EVAL;
      tsq_pkg::ST_PP_EVAL: begin
        if (slot_free) begin
          state_nxt = (cnt_r == ONE) ? tsq_pkg::ST_IDLE : tsq_pkg::ST_PS_WAIT;
        end
      end
      tsq_pkg::ST_PS_WAIT: state_nxt = tsq_pkg::ST_PS_EVAL;
      tsq_pkg::ST_PS_EVAL:
        state_nxt = (idx_r + ONE == cnt_r) ? tsq_pkg::ST_IDLE : tsq_pkg::ST_PS_WAIT;
      tsq_pkg::ST_DONE: begin
        if (slot_free) begin
          state_nxt = tsq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsq_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory writes and result register
  always_comb begin
    it_nxt   = it_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    w_nxt    = w_r;
    pos_nxt  = pos_r;
    keep_nxt = keep_r;
    repl_nxt = repl_r;
    fin_nxt  = fin_r;
    wr_en    = 1'b0;
    wr_addr  = IW'(idx_r);
    wr_data  = d;
    ov_nxt   = ov_r && !out_ready;
    ok_nxt   = ok_r;
    oe_nxt   = oe_r;
    ol_nxt   = ol_r;
    case (state_r)
      tsq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          it_nxt   = cmd;
          idx_nxt  = (cmd.op == tsq_pkg::OP_RESCHED) ? '0 : cnt_r;
          pos_nxt  = '0;
          repl_nxt = 1'b0;
          fin_nxt  = (cmd.op == tsq_pkg::OP_POP) ? tsq_pkg::RK_EMPTY
                                                 : tsq_pkg::RK_DONE;
        end
      end
      tsq_pkg::ST_IW_EVAL: begin
        if (!iw_stop) begin
          idx_nxt = jdx;
        end else if (!iw_hold) begin
          pos_nxt  = iw_pos;
          repl_nxt = iw_repl;
          idx_nxt  = cnt_r;
          if (iw_repl && rel_need) begin
            ov_nxt = 1'b1;
            ok_nxt = tsq_pkg::RK_RELEASE;
            oe_nxt = d;
            ol_nxt = 1'b0;
          end
          if (!iw_repl && full) begin
            fin_nxt = tsq_pkg::RK_FULL;
          end
        end
      end
      tsq_pkg::ST_IS_EVAL: begin
        wr_en   = 1'b1;
        wr_addr = IW'(idx_r);
        idx_nxt = jdx;
      end
      tsq_pkg::ST_IN_PUT: begin
        wr_en   = 1'b1;
        wr_addr = IW'(pos_r);
        wr_data = it_r.ent;
        if (!repl_r) begin
          cnt_nxt = cnt_r + ONE;
        end
      end
      tsq_pkg::ST_DK_EVAL: begin
        idx_nxt = jdx;
        if (pin_hit && !d_gt) begin
          keep_nxt = jdx;
        end
      end
      tsq_pkg::ST_DR_EVAL: begin
        if (!(pin_hit && rel_need && !slot_free)) begin
          if (pin_hit && rel_need) begin
            ov_nxt = 1'b1;
            ok_nxt = tsq_pkg::RK_RELEASE;
            oe_nxt = d;
            ol_nxt = 1'b0;
          end
          idx_nxt = jdx;
          w_nxt   = '0;
        end
      end
      tsq_pkg::ST_DC_EVAL: begin
        if (!dc_del) begin
          wr_en   = 1'b1;
          wr_addr = IW'(w_r);
          w_nxt   = w_r + ONE;
        end
        idx_nxt = idx_r + ONE;
        if (idx_r + ONE == cnt_r) begin
          cnt_nxt = dc_del ? w_r : w_r + ONE;
        end
      end
      tsq_pkg::ST_RS_EVAL: begin
        if (d_lt) begin
          wr_en          = 1'b1;
          wr_addr        = IW'(idx_r);
          wr_data.tstamp = it_r.ent.tstamp;
          idx_nxt        = idx_r + ONE;
        end
      end
      tsq_pkg::ST_PP_EVAL: begin
        if (slot_free) begin
          ov_nxt  = 1'b1;
          ok_nxt  = tsq_pkg::RK_POPPED;
          oe_nxt  = d;
          ol_nxt  = 1'b1;
          idx_nxt = ONE;
          if (cnt_r == ONE) begin
            cnt_nxt = '0;
          end
        end
      end
      tsq_pkg::ST_PS_EVAL: begin
        wr_en   = 1'b1;
        wr_addr = IW'(jdx);
        idx_nxt = idx_r + ONE;
        if (idx_r + ONE == cnt_r) begin
          cnt_nxt = cnt_r - ONE;
        end
      end
      tsq_pkg::ST_DONE: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          ok_nxt = fin_r;
          oe_nxt = '0;
          ol_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsq_pkg::ST_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    it_r   <= it_nxt;
    idx_r  <= idx_nxt;
    w_r    <= w_nxt;
    pos_r  <= pos_nxt;
    keep_r <= keep_nxt;
    repl_r <= repl_nxt;
    fin_r  <= fin_nxt;
    ok_r   <= ok_nxt;
    oe_r   <= oe_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid       = ov_r;
  assign out_result_kind = ok_r;
  assign out_time_out    = oe_r.tstamp;
  assign out_code_out    = oe_r.code;
  assign out_class_out   = oe_r.cls;
  assign out_pin_out     = oe_r.pin;
  assign out_payload_out = oe_r.pay;
  assign out_last        = ol_r;

  // checks on the sequencer
  `TSQ_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= FULL_CNT)
  `TSQ_ASSERT_IMPL(a_wr_busy, clk, rst_n, wr_en, state_r != tsq_pkg::ST_IDLE)
  `TSQ_ASSERT_NEXT(a_cmd_starts, clk, rst_n, cmd_valid && cmd_ready,
    state_r != tsq_pkg::ST_IDLE)

endmodule
`default_nettype wire

@@ sv/timestamp_ordered_event_queue.sv @@
// Top level of the timestamp ordered event queue
//
//  channel | ports                         | direction
//  in      | in_valid/in_ready + fields    | request into the queue
//  out     | out_valid/out_ready + fields  | results, last marks the final one
//
// Each request walks the sorted entries step by step: the entry memory has one
// registered read port, so every step waits for its data.
// Insert: walk from the tail plus shift. Discard: tail search, release walk and
// a compaction pass. Reschedule and pop walk the entries as well; the front
// register and command queue lie before the sequencer. A stalled result holds
// the sequencer only when it has another result to deliver. Reset empties the
// queue at once.
`default_nettype none
module timestamp_ordered_event_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   in_opcode,
  input  wire logic [31:0]  in_time_stamp,
  input  wire logic [7:0]   in_event_code,
  input  wire logic [1:0]   in_event_class,
  input  wire logic [7:0]   in_pin_index,
  input  wire logic [31:0]  in_payload,
  input  wire logic         in_payload_is_blob,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        out_result_kind,
  output logic [31:0]       out_time_out,
  output logic [7:0]        out_code_out,
  output logic [1:0]        out_class_out,
  output logic [7:0]        out_pin_out,
  output logic [31:0]       out_payload_out,
  output logic              out_last
);

  logic          f_valid, f_ready, b_valid, b_ready;
  tsq_pkg::cmd_t f_cmd, b_cmd;

  tsq_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_time_stamp,
    .in_event_code, .in_event_class, .in_pin_index, .in_payload,
    .in_payload_is_blob,
    .push_valid (f_valid), .push_ready (f_ready), .push_cmd (f_cmd)
  );

  tsq_fifo u_fifo (
    .clk, .rst_n,
    .push_valid (f_valid), .push_ready (f_ready), .push_cmd (f_cmd),
    .pop_valid (b_valid), .pop_ready (b_ready), .pop_cmd (b_cmd)
  );

  tsq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst_n,
    .cmd_valid (b_valid), .cmd_ready (b_ready), .cmd (b_cmd),
    .out_valid, .out_ready, .out_result_kind, .out_time_out, .out_code_out,
    .out_class_out, .out_pin_out, .out_payload_out, .out_last
  );

endmodule
`default_nettype wire
